/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* sv/cpt_pkg.sv */
// ---------------------------------------------------------------------------
// cpt_pkg
// Types and widths for the closest-point-on-triangle pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  localparam int CW   = 32;         // Q16.16 coordinate
  localparam int QB   = 34;         // quotient bits kept before saturation
  localparam int NUMW = 172;        // 2*|num| + |den|
  localparam int DVW  = 140;        // 2*|den|

  typedef struct packed {
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
    logic signed [CW-1:0] corner_a_x;
    logic signed [CW-1:0] corner_a_y;
    logic signed [CW-1:0] corner_a_z;
    logic signed [CW-1:0] corner_b_x;
    logic signed [CW-1:0] corner_b_y;
    logic signed [CW-1:0] corner_b_z;
    logic signed [CW-1:0] corner_c_x;
    logic signed [CW-1:0] corner_c_y;
    logic signed [CW-1:0] corner_c_z;
  } cpt_req_t;

  typedef struct packed {
    logic signed [CW-1:0] nearest_x;
    logic signed [CW-1:0] nearest_y;
    logic signed [CW-1:0] nearest_z;
  } cpt_rsp_t;

  typedef struct packed {
    logic                       direct;
    logic [2:0]                 neg;
    logic [2:0][CW-1:0]         base;
    logic [2:0][NUMW-1:0]       num;
    logic [DVW-1:0]             den;
  } div_req_t;

endpackage

`default_nettype wire

/* sv/cpt_div.sv */
// ---------------------------------------------------------------------------
// cpt_div
// Pipelined rounding divider, three lanes sharing one divisor, one quotient
// bit per stage, with final add to base and saturation, or base passed directly.
// ---------------------------------------------------------------------------
`default_nettype none

module cpt_div import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_rdy_o,
  input  div_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cpt_rsp_t out_data_o
);

  localparam int SUMW = CW + 4;

  logic [QB+1:0] v_q;
  logic [QB+1:0] v_in;
  logic [QB+1:0] en;

  logic [DVW-1:0] rem_q  [3][QB+1];
  logic [QB-1:0]  nlo_q  [3][QB+1];
  logic [QB-1:0]  quo_q  [3][QB+1];
  logic           ovf_q  [3][QB+1];
  logic [DVW-1:0] den_q  [QB+1];
  logic [2:0][CW-1:0] base_q [QB+1];
  logic [2:0]     neg_q  [QB+1];
  logic           dir_q  [QB+1];
  logic [CW-1:0]  res_q  [3];
  logic [CW-1:0]  res_d  [3];

  assign v_in = {v_q[QB:0], in_valid_i};

  always_comb begin
    en[QB+1] = !v_q[QB+1] || !out_stall_i;
    for (int k = QB; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_rdy_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k <= QB + 1; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      den_q[0]  <= in_data_i.den;
      base_q[0] <= in_data_i.base;
      neg_q[0]  <= in_data_i.neg;
      dir_q[0]  <= in_data_i.direct;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_init
    logic [NUMW-QB-1:0] hi;
    assign hi = in_data_i.num[l][NUMW-1:QB];
    always_ff @(posedge clk_i) begin
      if (en[0]) begin
        rem_q[l][0] <= DVW'(hi);
        nlo_q[l][0] <= in_data_i.num[l][QB-1:0];
        quo_q[l][0] <= '0;
        ovf_q[l][0] <= DVW'(hi) >= in_data_i.den;
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        den_q[k]  <= den_q[k-1];
        base_q[k] <= base_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        dir_q[k]  <= dir_q[k-1];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DVW:0]   cat;
      logic [DVW:0]   sub;
      logic           ge;
      logic [DVW-1:0] rem_d;
      assign cat   = {rem_q[l][k-1], nlo_q[l][k-1][QB-1]};
      assign sub   = cat - {1'b0, den_q[k-1]};
      assign ge    = cat >= {1'b0, den_q[k-1]};
      assign rem_d = ge ? sub[DVW-1:0] : cat[DVW-1:0];
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          rem_q[l][k] <= rem_d;
          nlo_q[l][k] <= {nlo_q[l][k-1][QB-2:0], 1'b0};
          quo_q[l][k] <= {quo_q[l][k-1][QB-2:0], ge};
          ovf_q[l][k] <= ovf_q[l][k-1];
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [SUMW-1:0] qs;
    logic [SUMW-1:0] qv;
    logic [SUMW-1:0] sum;
    logic            fits;
    assign qs   = SUMW'(quo_q[l][QB]);
    assign qv   = neg_q[QB][l] ? (~qs + 1'b1) : qs;
    assign sum  = SUMW'($signed(base_q[QB][l])) + qv;
    assign fits = (&sum[SUMW-1:CW-1]) || !(|sum[SUMW-1:CW-1]);
    always_comb begin
      if (dir_q[QB]) begin
        res_d[l] = base_q[QB][l];
      end else if (ovf_q[l][QB]) begin
        res_d[l] = neg_q[QB][l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else if (fits) begin
        res_d[l] = sum[CW-1:0];
      end else begin
        res_d[l] = sum[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[QB+1]) begin
        res_q[l] <= res_d[l];
      end
    end
  end

  assign out_valid_o          = v_q[QB+1];
  assign out_data_o.nearest_x = res_q[0];
  assign out_data_o.nearest_y = res_q[1];
  assign out_data_o.nearest_z = res_q[2];

endmodule

`default_nettype wire

/* sv/closest_point_on_triangle.sv */
// ---------------------------------------------------------------------------
// closest_point_on_triangle
// Closest point on a triangle to a query point, Voronoi region test,
// signed Q16.16 in and out, fully pipelined.
// ---------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | cpt_req_t (query, corners)
//   out     | output    | out_valid_o / out_stall_i | cpt_rsp_t (nearest point)
//
// One item per cycle while the output is not stalled; eleven arithmetic stages
// (differences, dot products, region terms, selection, numerator) followed
// by a divider setup stage, 34 stages at one quotient bit each and the
// saturating output.
// Reset clears only the valid bits. Each stage advances when it is empty or
// the stage after it advances, so bubbles close up under an output stall.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module closest_point_on_triangle import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cpt_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cpt_rsp_t out_data_o
);

  localparam int NS   = 11;
  localparam int XW   = CW + 1;
  localparam int PW   = 2 * XW;
  localparam int DW   = PW + 2;
  localparam int EW   = DW + 1;
  localparam int VW   = 2 * DW;
  localparam int DENW = VW + 2;
  localparam int MW   = XW + VW;
  localparam int NW   = MW + 1;
  localparam int HW   = DW / 2;
  localparam int MIDW = 2 * HW + 2;
  localparam int PPW  = XW + HW + 1;

  typedef enum logic [2:0] {
    REG_A, REG_B, REG_AB, REG_C, REG_AC, REG_BC, REG_FACE
  } region_e;

  logic [NS:1]   v_q;
  logic [NS:1]   v_in;
  logic [NS+1:1] en;
  logic          div_rdy;

  always_comb begin
    en[NS+1] = div_rdy;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in       = {v_q[NS-1:1], in_valid_i};
  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  logic signed [CW-1:0] p [3];
  logic signed [CW-1:0] a [3];
  logic signed [CW-1:0] b [3];
  logic signed [CW-1:0] c [3];

  assign p[0] = in_data_i.query_x;
  assign p[1] = in_data_i.query_y;
  assign p[2] = in_data_i.query_z;
  assign a[0] = in_data_i.corner_a_x;
  assign a[1] = in_data_i.corner_a_y;
  assign a[2] = in_data_i.corner_a_z;
  assign b[0] = in_data_i.corner_b_x;
  assign b[1] = in_data_i.corner_b_y;
  assign b[2] = in_data_i.corner_b_z;
  assign c[0] = in_data_i.corner_c_x;
  assign c[1] = in_data_i.corner_c_y;
  assign c[2] = in_data_i.corner_c_z;

  // stage 1: differences
  logic signed [XW-1:0] ab1_q [3];
  logic signed [XW-1:0] ac1_q [3];
  logic signed [XW-1:0] bc1_q [3];
  logic signed [XW-1:0] ap1_q [3];
  logic signed [XW-1:0] bp1_q [3];
  logic signed [XW-1:0] cp1_q [3];
  logic signed [CW-1:0] a1_q  [3];
  logic signed [CW-1:0] b1_q  [3];
  logic signed [CW-1:0] c1_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        ab1_q[k] <= XW'(b[k]) - XW'(a[k]);
        ac1_q[k] <= XW'(c[k]) - XW'(a[k]);
        bc1_q[k] <= XW'(c[k]) - XW'(b[k]);
        ap1_q[k] <= XW'(p[k]) - XW'(a[k]);
        bp1_q[k] <= XW'(p[k]) - XW'(b[k]);
        cp1_q[k] <= XW'(p[k]) - XW'(c[k]);
        a1_q[k]  <= a[k];
        b1_q[k]  <= b[k];
        c1_q[k]  <= c[k];
      end
    end
  end

  // stage 2: dot product terms
  logic signed [PW-1:0] pr2_q [6][3];
  logic signed [XW-1:0] ab2_q [3];
  logic signed [XW-1:0] ac2_q [3];
  logic signed [XW-1:0] bc2_q [3];
  logic signed [CW-1:0] a2_q  [3];
  logic signed [CW-1:0] b2_q  [3];
  logic signed [CW-1:0] c2_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        pr2_q[0][k] <= ab1_q[k] * ap1_q[k];
        pr2_q[1][k] <= ac1_q[k] * ap1_q[k];
        pr2_q[2][k] <= ab1_q[k] * bp1_q[k];
        pr2_q[3][k] <= ac1_q[k] * bp1_q[k];
        pr2_q[4][k] <= ab1_q[k] * cp1_q[k];
        pr2_q[5][k] <= ac1_q[k] * cp1_q[k];
        ab2_q[k]    <= ab1_q[k];
        ac2_q[k]    <= ac1_q[k];
        bc2_q[k]    <= bc1_q[k];
        a2_q[k]     <= a1_q[k];
        b2_q[k]     <= b1_q[k];
        c2_q[k]     <= c1_q[k];
      end
    end
  end

  // stage 3: d1..d6
  logic signed [DW-1:0] d3_q  [6];
  logic signed [XW-1:0] ab3_q [3];
  logic signed [XW-1:0] ac3_q [3];
  logic signed [XW-1:0] bc3_q [3];
  logic signed [CW-1:0] a3_q  [3];
  logic signed [CW-1:0] b3_q  [3];
  logic signed [CW-1:0] c3_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int j = 0; j < 6; j++) begin
        d3_q[j] <= DW'(pr2_q[j][0]) + DW'(pr2_q[j][1]) + DW'(pr2_q[j][2]);
      end
      for (int k = 0; k < 3; k++) begin
        ab3_q[k] <= ab2_q[k];
        ac3_q[k] <= ac2_q[k];
        bc3_q[k] <= bc2_q[k];
        a3_q[k]  <= a2_q[k];
        b3_q[k]  <= b2_q[k];
        c3_q[k]  <= c2_q[k];
      end
    end
  end

  // stage 4: region term partial products, split at HW bits
  logic signed [DW-1:0]     mx [6];
  logic signed [DW-1:0]     my [6];
  logic        [2*HW-1:0]   ll4_q [6];
  logic signed [2*HW-1:0]   hh4_q [6];
  logic signed [2*HW:0]     hl4_q [6];
  logic signed [2*HW:0]     lh4_q [6];
  logic signed [DW-1:0]     d4_q  [6];
  logic signed [XW-1:0]     ab4_q [3];
  logic signed [XW-1:0]     ac4_q [3];
  logic signed [XW-1:0]     bc4_q [3];
  logic signed [CW-1:0]     a4_q  [3];
  logic signed [CW-1:0]     b4_q  [3];
  logic signed [CW-1:0]     c4_q  [3];

  always_comb begin
    mx[0] = d3_q[0];
    my[0] = d3_q[3];
    mx[1] = d3_q[2];
    my[1] = d3_q[1];
    mx[2] = d3_q[4];
    my[2] = d3_q[1];
    mx[3] = d3_q[0];
    my[3] = d3_q[5];
    mx[4] = d3_q[2];
    my[4] = d3_q[5];
    mx[5] = d3_q[4];
    my[5] = d3_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int j = 0; j < 6; j++) begin
        ll4_q[j] <= mx[j][HW-1:0] * my[j][HW-1:0];
        hh4_q[j] <= $signed(mx[j][DW-1:HW]) * $signed(my[j][DW-1:HW]);
        hl4_q[j] <= $signed(mx[j][DW-1:HW]) * $signed({1'b0, my[j][HW-1:0]});
        lh4_q[j] <= $signed({1'b0, mx[j][HW-1:0]}) * $signed(my[j][DW-1:HW]);
      end
      d4_q  <= d3_q;
      ab4_q <= ab3_q;
      ac4_q <= ac3_q;
      bc4_q <= bc3_q;
      a4_q  <= a3_q;
      b4_q  <= b3_q;
      c4_q  <= c3_q;
    end
  end

  // stage 5: region term products
  logic signed [MIDW-1:0] mid5 [6];
  logic signed [VW-1:0]   m5_q  [6];
  logic signed [DW-1:0]   d5_q  [6];
  logic signed [XW-1:0]   ab5_q [3];
  logic signed [XW-1:0]   ac5_q [3];
  logic signed [XW-1:0]   bc5_q [3];
  logic signed [CW-1:0]   a5_q  [3];
  logic signed [CW-1:0]   b5_q  [3];
  logic signed [CW-1:0]   c5_q  [3];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      mid5[j] = MIDW'(hl4_q[j]) + MIDW'(lh4_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int j = 0; j < 6; j++) begin
        m5_q[j] <= $signed({hh4_q[j], ll4_q[j]}) + (VW'(mid5[j]) <<< HW);
      end
      d5_q  <= d4_q;
      ab5_q <= ab4_q;
      ac5_q <= ac4_q;
      bc5_q <= bc4_q;
      a5_q  <= a4_q;
      b5_q  <= b4_q;
      c5_q  <= c4_q;
    end
  end

  // stage 6: va, vb, vc and edge differences
  logic signed [VW-1:0] va6_q, vb6_q, vc6_q;
  logic signed [EW-1:0] e13_6_q, e26_6_q, e43_6_q, e56_6_q;
  logic signed [DW-1:0] d6_q  [6];
  logic signed [XW-1:0] ab6_q [3];
  logic signed [XW-1:0] ac6_q [3];
  logic signed [XW-1:0] bc6_q [3];
  logic signed [CW-1:0] a6_q  [3];
  logic signed [CW-1:0] b6_q  [3];
  logic signed [CW-1:0] c6_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      vc6_q   <= m5_q[0] - m5_q[1];
      vb6_q   <= m5_q[2] - m5_q[3];
      va6_q   <= m5_q[4] - m5_q[5];
      e13_6_q <= EW'(d5_q[0]) - EW'(d5_q[2]);
      e26_6_q <= EW'(d5_q[1]) - EW'(d5_q[5]);
      e43_6_q <= EW'(d5_q[3]) - EW'(d5_q[2]);
      e56_6_q <= EW'(d5_q[4]) - EW'(d5_q[5]);
      d6_q    <= d5_q;
      ab6_q   <= ab5_q;
      ac6_q   <= ac5_q;
      bc6_q   <= bc5_q;
      a6_q    <= a5_q;
      b6_q    <= b5_q;
      c6_q    <= c5_q;
    end
  end

  // stage 7: region select
  logic    d1_le, d1_ge, d2_le, d2_ge, d3_le, d3_ge, d6_le, d6_ge;
  logic    e43_le, e43_ge, e56_le, e56_ge, va_le, vb_le, vc_le;
  region_e rg;

  assign d1_le  = d6_q[0][DW-1] || (d6_q[0] == '0);
  assign d1_ge  = !d6_q[0][DW-1];
  assign d2_le  = d6_q[1][DW-1] || (d6_q[1] == '0);
  assign d2_ge  = !d6_q[1][DW-1];
  assign d3_le  = d6_q[2][DW-1] || (d6_q[2] == '0);
  assign d3_ge  = !d6_q[2][DW-1];
  assign d6_le  = d6_q[5][DW-1] || (d6_q[5] == '0);
  assign d6_ge  = !d6_q[5][DW-1];
  assign e43_le = e43_6_q[EW-1] || (e43_6_q == '0);
  assign e43_ge = !e43_6_q[EW-1];
  assign e56_le = e56_6_q[EW-1] || (e56_6_q == '0);
  assign e56_ge = !e56_6_q[EW-1];
  assign va_le  = va6_q[VW-1] || (va6_q == '0);
  assign vb_le  = vb6_q[VW-1] || (vb6_q == '0);
  assign vc_le  = vc6_q[VW-1] || (vc6_q == '0);

  always_comb begin
    if (d1_le && d2_le) begin
      rg = REG_A;
    end else if (d3_ge && e43_le) begin
      rg = REG_B;
    end else if (vc_le && d1_ge && d3_le) begin
      rg = REG_AB;
    end else if (d6_ge && e56_le) begin
      rg = REG_C;
    end else if (vb_le && d2_ge && d6_le) begin
      rg = REG_AC;
    end else if (va_le && e43_ge && e56_ge) begin
      rg = REG_BC;
    end else begin
      rg = REG_FACE;
    end
  end

  logic                   dir7_d;
  logic signed [CW-1:0]   base7_d [3];
  logic signed [XW-1:0]   e1_7_d  [3];
  logic signed [XW-1:0]   e2_7_d  [3];
  logic signed [VW-1:0]   s1_7_d, s2_7_d;
  logic signed [DENW-1:0] den7_d;

  always_comb begin
    dir7_d  = 1'b0;
    base7_d = a6_q;
    e1_7_d  = ab6_q;
    e2_7_d  = ac6_q;
    s1_7_d  = '0;
    s2_7_d  = '0;
    den7_d  = '0;
    case (rg)
      REG_A: begin
        dir7_d = 1'b1;
      end
      REG_B: begin
        dir7_d  = 1'b1;
        base7_d = b6_q;
      end
      REG_C: begin
        dir7_d  = 1'b1;
        base7_d = c6_q;
      end
      REG_AB: begin
        s1_7_d = VW'(d6_q[0]);
        den7_d = DENW'(e13_6_q);
      end
      REG_AC: begin
        e1_7_d = ac6_q;
        s1_7_d = VW'(d6_q[1]);
        den7_d = DENW'(e26_6_q);
      end
      REG_BC: begin
        base7_d = b6_q;
        e1_7_d  = bc6_q;
        s1_7_d  = VW'(e43_6_q);
        den7_d  = DENW'(e43_6_q) + DENW'(e56_6_q);
      end
      default: begin
        s1_7_d = vb6_q;
        s2_7_d = vc6_q;
        den7_d = DENW'(va6_q) + DENW'(vb6_q) + DENW'(vc6_q);
      end
    endcase
  end

  logic                   dir7_q;
  logic signed [CW-1:0]   base7_q [3];
  logic signed [XW-1:0]   e1_7_q  [3];
  logic signed [XW-1:0]   e2_7_q  [3];
  logic signed [VW-1:0]   s1_7_q, s2_7_q;
  logic signed [DENW-1:0] den7_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      dir7_q  <= dir7_d;
      base7_q <= base7_d;
      e1_7_q  <= e1_7_d;
      e2_7_q  <= e2_7_d;
      s1_7_q  <= s1_7_d;
      s2_7_q  <= s2_7_d;
      den7_q  <= den7_d;
    end
  end

  // stage 8: numerator partial products, weights split at HW bits
  logic signed [PPW-1:0]  pp8_q [2][3][4];
  logic                   dir8_q;
  logic signed [CW-1:0]   base8_q [3];
  logic signed [DENW-1:0] den8_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pp8_q[0][k][i] <= e1_7_q[k] * $signed({1'b0, s1_7_q[i*HW +: HW]});
          pp8_q[1][k][i] <= e2_7_q[k] * $signed({1'b0, s2_7_q[i*HW +: HW]});
        end
        pp8_q[0][k][3] <= e1_7_q[k] * $signed(s1_7_q[VW-1 -: HW]);
        pp8_q[1][k][3] <= e2_7_q[k] * $signed(s2_7_q[VW-1 -: HW]);
      end
      dir8_q  <= dir7_q || (den7_q == '0);
      base8_q <= base7_q;
      den8_q  <= den7_q;
    end
  end

  // stage 9: numerator products
  logic signed [MW-1:0]   pm9_q [2][3];
  logic                   dir9_q;
  logic signed [CW-1:0]   base9_q [3];
  logic signed [DENW-1:0] den9_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      for (int t = 0; t < 2; t++) begin
        for (int k = 0; k < 3; k++) begin
          pm9_q[t][k] <= (MW'(pp8_q[t][k][0]) + (MW'(pp8_q[t][k][1]) <<< HW))
                       + ((MW'(pp8_q[t][k][2]) <<< (2 * HW))
                       + (MW'(pp8_q[t][k][3]) <<< (3 * HW)));
        end
      end
      dir9_q  <= dir8_q;
      base9_q <= base8_q;
      den9_q  <= den8_q;
    end
  end

  // stage 10: numerator sum
  logic signed [NW-1:0]   num10_q [3];
  logic                   dir10_q;
  logic signed [CW-1:0]   base10_q [3];
  logic signed [DENW-1:0] den10_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      for (int k = 0; k < 3; k++) begin
        num10_q[k] <= NW'(pm9_q[0][k]) + NW'(pm9_q[1][k]);
      end
      dir10_q  <= dir9_q;
      base10_q <= base9_q;
      den10_q  <= den9_q;
    end
  end

  // stage 11: magnitudes and rounding offset
  logic [DENW-1:0] ud;
  logic [NW-1:0]   un [3];
  div_req_t        req11_d;
  div_req_t        req11_q;

  assign ud = den10_q[DENW-1] ? (~den10_q + 1'b1) : den10_q;

  always_comb begin
    req11_d.direct = dir10_q;
    req11_d.den    = DVW'({ud, 1'b0});
    for (int k = 0; k < 3; k++) begin
      un[k]              = num10_q[k][NW-1] ? (~num10_q[k] + 1'b1) : num10_q[k];
      req11_d.neg[k]     = num10_q[k][NW-1] ^ den10_q[DENW-1];
      req11_d.base[k]    = base10_q[k];
      req11_d.num[k]     = NUMW'({un[k], 1'b0}) + NUMW'(ud);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      req11_q <= req11_d;
    end
  end

  cpt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[NS]),
    .in_rdy_o    (div_rdy),
    .in_data_i   (req11_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o |-> (&v_q), "input stalled with a free stage")
  `ASSERT_IMPL(a_den_live, clk_i, rst_ni, (v_q[NS] && !req11_q.direct) |-> (req11_q.den != '0), "zero divisor sent to divider")
  `ASSERT_NEVER(a_face_den, clk_i, rst_ni, v_q[8] && !dir8_q && (den8_q == '0), "blend with zero divisor")

endmodule

`default_nettype wire
